// ===== rtl/asp_pkg.sv =====
// Shared types, constants and control structs for the atlas shelf packer.
// Used by asp_ctrl, asp_datapath and the top level (not by asp_ram); depends on nothing.
`default_nettype none

package asp_pkg;

    localparam int MAX_RECTS_DEF = 64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING     = 1'd1;

    localparam logic [12:0] ATLAS_WIDTH_RST = 13'd512;
    localparam logic [3:0]  PADDING_RST     = 4'd1;

    localparam logic [12:0] XMAX     = 13'd8191;
    localparam logic [16:0] YMAX     = 17'd131071;
    localparam logic [11:0] POSX_MAX = 12'd4095;

    typedef struct packed {
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic        final_rect;
    } rect_t;

    typedef struct packed {
        logic [5:0]  rect_index;
        logic [11:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] total_height;
        logic        last_out;
    } place_t;

    typedef enum logic [1:0] {
        ADR_I,
        ADR_J,
        ADR_K
    } adr_sel_t;

    typedef struct packed {
        logic     load;
        logic     i_clear;
        logic     row_start;
        logic     cmp_step;
        logic     row_wb;
        logic     k_clear;
        logic     place_step;
        logic     out_load;
        adr_sel_t adr_sel;
    } asp_cmd_t;

    typedef struct packed {
        logic sort_done;
        logic j_last;
        logic k_last;
        logic out_free;
    } asp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/asp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module asp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/asp_ctrl.sv =====
// Sequencer for loading, exchange sort, shelf placement and result output.
// Depends on asp_pkg for the command and status structs.
`default_nettype none

module asp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rect_valid,
    input  wire logic              final_rect,
    output logic                   rect_ready,
    input  wire asp_pkg::asp_stat_t stat,
    output asp_pkg::asp_cmd_t      cmd
);
    import asp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_ROW   = 10'b00_0000_0010,
        S_ROWD  = 10'b00_0000_0100,
        S_RD    = 10'b00_0000_1000,
        S_CMP   = 10'b00_0001_0000,
        S_WB    = 10'b00_0010_0000,
        S_PRD   = 10'b00_0100_0000,
        S_PCALC = 10'b00_1000_0000,
        S_ORD   = 10'b01_0000_0000,
        S_OCAP  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.adr_sel = ADR_K;
        rect_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rect_ready = 1'b1;
                cmd.load   = rect_valid;
                if (rect_valid && final_rect)
                begin
                    cmd.i_clear = 1'b1;
                    state_next  = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.adr_sel = ADR_I;
                if (stat.sort_done)
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = S_PRD;
                end
                else
                begin
                    state_next = S_ROWD;
                end
            end
            S_ROWD:
            begin
                cmd.row_start = 1'b1;
                state_next    = S_RD;
            end
            S_RD:
            begin
                cmd.adr_sel = ADR_J;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = stat.j_last ? S_WB : S_RD;
            end
            S_WB:
            begin
                cmd.row_wb = 1'b1;
                state_next = S_ROW;
            end
            S_PRD:
            begin
                state_next = S_PCALC;
            end
            S_PCALC:
            begin
                cmd.place_step = 1'b1;
                if (stat.k_last)
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = S_ORD;
                end
                else
                begin
                    state_next = S_PRD;
                end
            end
            S_ORD:
            begin
                state_next = S_OCAP;
            end
            S_OCAP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.k_last ? S_IDLE : S_ORD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/asp_datapath.sv =====
// Datapath: rectangle store, sort cursor, shelf placement arithmetic,
// position store, configuration registers and the result register.
// Depends on asp_pkg and asp_ram.
`default_nettype none

module asp_datapath #(
    parameter int MAX_RECTS = asp_pkg::MAX_RECTS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire asp_pkg::rect_t            rect,
    input  wire logic                      cfg_valid,
    input  wire logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [asp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire asp_pkg::asp_cmd_t         cmd,
    output asp_pkg::asp_stat_t             stat,
    output logic                           place_valid,
    input  wire logic                      place_ready,
    output asp_pkg::place_t                place
);
    import asp_pkg::*;

    localparam int IDX_W = $clog2(MAX_RECTS);
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int ENT_W = IDX_W + 22;
    localparam int POS_W = 29;

    logic [12:0]      atlas_width_reg;
    logic [3:0]       padding_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic [ENT_W-1:0] cur_reg;
    logic [12:0]      cx_reg;
    logic [16:0]      cy_reg;
    logic [11:0]      row_reg;
    logic [16:0]      ah_reg;
    place_t           place_reg;
    logic             place_valid_reg;

    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    logic [ENT_W-1:0] ent_wdata;
    logic [IDX_W-1:0] ent_raddr;
    logic [ENT_W-1:0] ent_rdata;
    logic [POS_W-1:0] pos_rdata;
    logic             not_full;
    logic             swap;

    logic [10:0] rw;
    logic [10:0] rh;
    logic        first;
    logic [11:0] nrow;
    logic [11:0] row_base;
    logic [16:0] ah_base;
    logic [16:0] cy_base;
    logic [12:0] cx_base;
    logic [13:0] fit_sum;
    logic        wrap;
    logic [17:0] ah_sum;
    logic [17:0] cy_sum;
    logic [16:0] ah_sat;
    logic [16:0] cy_sat;
    logic [12:0] cx_at;
    logic [16:0] cy_at;
    logic [13:0] cx_sum;
    logic [12:0] cx_adv;
    logic [11:0] px_sat;

    assign not_full = count_reg < CNT_W'(MAX_RECTS);
    assign swap     = cur_reg[IDX_W+10:IDX_W] < ent_rdata[IDX_W+10:IDX_W];

    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = k_reg;
        ent_wdata = cur_reg;
        if (cmd.load)
        begin
            ent_we    = not_full;
            ent_waddr = count_reg[IDX_W-1:0];
            ent_wdata = {rect.rect_width, rect.rect_height, count_reg[IDX_W-1:0]};
        end
        else if (cmd.cmp_step)
        begin
            ent_we    = swap;
            ent_waddr = j_reg;
        end
        else if (cmd.row_wb)
        begin
            ent_we    = 1'b1;
            ent_waddr = i_reg;
        end
    end

    always_comb
    begin
        case (cmd.adr_sel)
            ADR_I:   ent_raddr = i_reg;
            ADR_J:   ent_raddr = j_reg;
            ADR_K:   ent_raddr = k_reg;
            default: ent_raddr = k_reg;
        endcase
    end

    asp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RECTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    assign rw    = ent_rdata[IDX_W+21:IDX_W+11];
    assign rh    = ent_rdata[IDX_W+10:IDX_W];
    assign first = (k_reg == '0);

    always_comb
    begin
        nrow     = 12'(rh) + 12'(padding_reg);
        row_base = first ? nrow : row_reg;
        ah_base  = first ? 17'(nrow) : ah_reg;
        cy_base  = first ? 17'd0 : cy_reg;
        cx_base  = first ? 13'(5'd1 + 5'(padding_reg)) : cx_reg;
        fit_sum  = 14'(cx_base) + 14'(rw);
        wrap     = fit_sum > 14'(atlas_width_reg);
        ah_sum   = 18'(ah_base) + 18'(nrow);
        cy_sum   = 18'(cy_base) + 18'(row_base);
        ah_sat   = (ah_sum > 18'(YMAX)) ? YMAX : ah_sum[16:0];
        cy_sat   = (cy_sum > 18'(YMAX)) ? YMAX : cy_sum[16:0];
        cx_at    = wrap ? 13'd0 : cx_base;
        cy_at    = wrap ? cy_sat : cy_base;
        cx_sum   = 14'(cx_at) + 14'(rw) + 14'(padding_reg);
        cx_adv   = (cx_sum > 14'(XMAX)) ? XMAX : cx_sum[12:0];
        px_sat   = (cx_at > 13'(POSX_MAX)) ? POSX_MAX : cx_at[11:0];
    end

    asp_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_RECTS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (cmd.place_step),
        .wr_addr (k_reg),
        .wr_data ({px_sat, cy_at}),
        .rd_addr (k_reg),
        .rd_data (pos_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg <= ATLAS_WIDTH_RST;
            padding_reg     <= PADDING_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ATLAS_WIDTH: atlas_width_reg <= cfg_data;
                REG_PADDING:     padding_reg     <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.out_load && stat.k_last)
            begin
                count_reg <= '0;
            end
            else if (cmd.load && not_full)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.i_clear)
            begin
                i_reg <= '0;
            end
            else if (cmd.row_wb)
            begin
                i_reg <= i_reg + 1'b1;
            end

            if (cmd.row_start)
            begin
                j_reg <= i_reg + 1'b1;
            end
            else if (cmd.cmp_step)
            begin
                j_reg <= j_reg + 1'b1;
            end

            if (cmd.k_clear)
            begin
                k_reg <= '0;
            end
            else if (cmd.place_step || cmd.out_load)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_start || (cmd.cmp_step && swap))
        begin
            cur_reg <= ent_rdata;
        end
        if (cmd.place_step)
        begin
            cx_reg  <= cx_adv;
            cy_reg  <= cy_at;
            row_reg <= wrap ? nrow : row_base;
            ah_reg  <= wrap ? ah_sat : ah_base;
        end
        if (cmd.out_load)
        begin
            place_reg.rect_index   <= 6'(ent_rdata[IDX_W-1:0]);
            place_reg.pos_x        <= pos_rdata[28:17];
            place_reg.pos_y        <= pos_rdata[16:0];
            place_reg.total_height <= ah_reg;
            place_reg.last_out     <= stat.k_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            place_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            place_valid_reg <= 1'b1;
        end
        else if (place_ready)
        begin
            place_valid_reg <= 1'b0;
        end
    end

    assign stat.sort_done = (CNT_W'(i_reg) + 1'b1) >= count_reg;
    assign stat.j_last    = (CNT_W'(j_reg) + 1'b1) == count_reg;
    assign stat.k_last    = (CNT_W'(k_reg) + 1'b1) == count_reg;
    assign stat.out_free  = !place_valid_reg || place_ready;

    assign place_valid = place_valid_reg;
    assign place       = place_reg;

endmodule

`default_nettype wire

// ===== rtl/atlas_shelf_packer.sv =====
// Top level of the atlas shelf packer; depends on asp_pkg, asp_ctrl, asp_datapath and asp_ram.
// Loading accepts one request per cycle while the sequencer is idle. After the final
// request of a set, the exchange sort reads and compares each pair in turn, placement
// reads and places each rectangle, and output registers each result once the sink frees
// the result register. Reset is asynchronous: it clears the sequencer, counters and
// result valid, restores atlas width 512 and padding 1, and leaves the RAMs uncleared.
`default_nettype none

module atlas_shelf_packer #(
    parameter int MAX_RECTS = asp_pkg::MAX_RECTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rect_valid,
    output logic                                rect_ready,
    input  wire asp_pkg::rect_t                 rect,
    output logic                                place_valid,
    input  wire logic                           place_ready,
    output asp_pkg::place_t                     place,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [asp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import asp_pkg::*;

    asp_cmd_t  cmd;
    asp_stat_t stat;

    assign cfg_ready = 1'b1;

    asp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .rect_valid (rect_valid),
        .final_rect (rect.final_rect),
        .rect_ready (rect_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    asp_datapath #(
        .MAX_RECTS (MAX_RECTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .rect        (rect),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .place_valid (place_valid),
        .place_ready (place_ready),
        .place       (place)
    );

endmodule

`default_nettype wire

// ===== tb/atlas_shelf_packer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for atlas_shelf_packer: loads rectangle sets over the request
// channel, predicts the sorted shelf placement of each set and checks every placement result.
// Depends on asp_pkg and the atlas_shelf_packer RTL only.

module atlas_shelf_packer_tb;

    import asp_pkg::*;

    localparam int RECT_CAP    = MAX_RECTS_DEF;
    localparam int DRAIN_GAP   = 40;
    localparam int END_GAP     = 100;
    localparam int QUIET_TAIL  = 40;
    localparam int RECT_TARGET = 470;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum logic [1:0] {
        OP_RECT,
        OP_REG,
        OP_DRAIN
    } feed_op_t;

    typedef struct packed {
        feed_op_t                op;
        rect_t                   rect;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
    } feed_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  rect_valid = 1'b0;
    logic                  rect_ready;
    rect_t                 rect = '0;
    logic                  place_valid;
    logic                  place_ready = 1'b0;
    place_t                place;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    feed_t  rect_feed_q[$];
    place_t placement_q[$];

    logic [12:0] atlas_w_m = ATLAS_WIDTH_RST;
    logic [3:0]  pad_m = PADDING_RST;
    logic [10:0] width_mem [RECT_CAP];
    logic [10:0] height_mem [RECT_CAP];
    logic [5:0]  order_mem [RECT_CAP];
    int unsigned held = 0;

    int send_wait = 0;
    int send_calm = 0;
    int recv_wait = 0;
    int recv_calm = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;
    int queued_rects = 0;

    atlas_shelf_packer #(
        .MAX_RECTS(RECT_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rect_valid(rect_valid),
        .rect_ready(rect_ready),
        .rect(rect),
        .place_valid(place_valid),
        .place_ready(place_ready),
        .place(place),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clip(int unsigned v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // Stores one rectangle and, at the end of a set, sorts tallest first and places the shelf.
    function automatic void pack_rect(rect_t r);
        int unsigned n, i, j, k, a, b, e, rw, rh, pd;
        int unsigned cx, cy, row_h, atl_h;
        int unsigned px [RECT_CAP];
        int unsigned py [RECT_CAP];
        place_t res;
        if (held < RECT_CAP)
        begin
            width_mem[held] = r.rect_width;
            height_mem[held] = r.rect_height;
            order_mem[held] = 6'(held);
            held++;
        end
        if (r.final_rect)
        begin
            n = held;
            for (i = 0; i < n; i++)
            begin
                for (j = i + 1; j < n; j++)
                begin
                    a = order_mem[i];
                    b = order_mem[j];
                    if (height_mem[a] < height_mem[b])
                    begin
                        order_mem[i] = 6'(b);
                        order_mem[j] = 6'(a);
                    end
                end
            end
            pd = pad_m;
            cx = 0;
            cy = 0;
            row_h = 0;
            atl_h = 0;
            for (k = 0; k < n; k++)
            begin
                e = order_mem[k];
                rw = width_mem[e];
                rh = height_mem[e];
                if (k == 0)
                begin
                    row_h = rh + pd;
                    atl_h = clip(row_h, YMAX);
                    cx = 1 + pd;
                end
                if (cx + rw > atlas_w_m)
                begin
                    atl_h = clip(atl_h + rh + pd, YMAX);
                    cx = 0;
                    cy = clip(cy + row_h, YMAX);
                    row_h = rh + pd;
                end
                px[k] = cx;
                py[k] = cy;
                cx = clip(cx + rw + pd, XMAX);
            end
            for (k = 0; k < n; k++)
            begin
                res.rect_index = order_mem[k];
                res.pos_x = 12'(clip(px[k], POSX_MAX));
                res.pos_y = 17'(py[k]);
                res.total_height = 17'(atl_h);
                res.last_out = (k + 1 == n);
                placement_q.push_back(res);
            end
            held = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        feed_t cmd;
        logic  rv_nxt;
        logic  cv_nxt;
        if (!rst_n)
        begin
            rect_valid <= 1'b0;
            cfg_valid <= 1'b0;
            rect <= '0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else
        begin
            rv_nxt = rect_valid;
            cv_nxt = cfg_valid;
            if (rect_valid && rect_ready)
            begin
                pack_rect(rect);
                rv_nxt = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ATLAS_WIDTH)
                    atlas_w_m = cfg_data;
                else if (cfg_index == REG_PADDING)
                    pad_m = cfg_data[3:0];
                cv_nxt = 1'b0;
            end
            if (!rv_nxt && !cv_nxt && rect_feed_q.size() > 0)
            begin
                if (send_wait > 0)
                    send_wait--;
                else
                begin
                    cmd = rect_feed_q[0];
                    case (cmd.op)
                        OP_DRAIN:
                        begin
                            if (placement_q.size() == 0)
                            begin
                                void'(rect_feed_q.pop_front());
                                send_wait = DRAIN_GAP;
                            end
                        end
                        OP_REG:
                        begin
                            void'(rect_feed_q.pop_front());
                            cfg_index <= cmd.reg_index;
                            cfg_data <= cmd.reg_data;
                            cv_nxt = 1'b1;
                        end
                        default:
                        begin
                            void'(rect_feed_q.pop_front());
                            rect <= cmd.rect;
                            rv_nxt = 1'b1;
                            if (rect_feed_q.size() <= QUIET_TAIL)
                                send_wait = 0;
                            else if (send_calm > 0)
                                send_calm--;
                            else
                            begin
                                case ($urandom_range(0, 9))
                                    0, 1, 2: send_wait = $urandom_range(1, 13);
                                    3:       send_calm = $urandom_range(10, 60);
                                    default: ;
                                endcase
                            end
                        end
                    endcase
                end
            end
            rect_valid <= rv_nxt;
            cfg_valid <= cv_nxt;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        place_t want;
        if (!rst_n)
            place_ready <= 1'b0;
        else
        begin
            if (place_valid && place_ready)
            begin
                if (placement_q.size() == 0)
                begin
                    $error("placement result for rect_index %0d with none expected",
                           place.rect_index);
                    fail_cnt++;
                end
                else
                begin
                    want = placement_q.pop_front();
                    check_field("rect_index", want.rect_index, place.rect_index);
                    check_field("pos_x", want.pos_x, place.pos_x);
                    check_field("pos_y", want.pos_y, place.pos_y);
                    check_field("total_height", want.total_height, place.total_height);
                    check_field("last_out", want.last_out, place.last_out);
                end
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                place_ready <= 1'b0;
            end
            else if (rect_feed_q.size() <= QUIET_TAIL)
                place_ready <= 1'b1;
            else if (recv_calm > 0)
            begin
                recv_calm--;
                place_ready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0:
                    begin
                        recv_wait = $urandom_range(0, 12);
                        place_ready <= 1'b0;
                    end
                    1:
                    begin
                        recv_calm = $urandom_range(20, 120);
                        place_ready <= 1'b1;
                    end
                    default: place_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("atlas_shelf_packer test failed");
            $finish;
        end
    end

    task automatic push_rect(int unsigned w, int unsigned h, bit fin);
        feed_t e;
        e = '0;
        e.op = OP_RECT;
        e.rect.rect_width = 11'(w);
        e.rect.rect_height = 11'(h);
        e.rect.final_rect = fin;
        rect_feed_q.push_back(e);
        queued_rects++;
    endtask

    // Waits for the block to drain, then rewrites both registers.
    task automatic retune(int unsigned width_val, int unsigned pad_val);
        feed_t e;
        e = '0;
        e.op = OP_DRAIN;
        rect_feed_q.push_back(e);
        e.op = OP_REG;
        e.reg_index = REG_ATLAS_WIDTH;
        e.reg_data = CFG_DATA_W'(width_val);
        rect_feed_q.push_back(e);
        e.reg_index = REG_PADDING;
        e.reg_data = CFG_DATA_W'(pad_val);
        rect_feed_q.push_back(e);
    endtask

    task automatic push_random_set(int n);
        bit ties;
        bit wild;
        int unsigned w, h;
        ties = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            wild = ($urandom_range(0, 7) == 0);
            w = wild ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
            if (wild)
                h = $urandom_range(0, 2047);
            else if (ties)
                h = $urandom_range(1, 4);
            else
                h = $urandom_range(1, 1024);
            push_rect(w, h, i == n - 1);
        end
    endtask

    initial
    begin
        int phase_rects;
        int unsigned width_val, pad_val;
        int set_len;

        retune(ATLAS_WIDTH_RST, PADDING_RST);
        push_rect(1, 1, 1'b1);
        push_rect(1024, 1, 1'b0);
        push_rect(1, 1024, 1'b0);
        push_rect(300, 500, 1'b0);
        push_rect(5, 500, 1'b1);
        push_rect(0, 0, 1'b0);
        push_rect(2047, 2047, 1'b1);

        retune(0, 0);
        push_rect(1, 2, 1'b0);
        push_rect(3, 4, 1'b0);
        push_rect(5, 6, 1'b1);

        // Cursor runs into the right edge of the widest atlas and saturates.
        retune(8191, 15);
        push_rect(2047, 9, 1'b0);
        push_rect(2047, 9, 1'b0);
        push_rect(2047, 9, 1'b0);
        push_rect(1989, 9, 1'b0);
        push_rect(0, 9, 1'b0);
        push_rect(0, 9, 1'b1);

        retune(16, 15);
        push_rect(1, 1, 1'b0);
        push_rect(1, 1, 1'b0);
        push_rect(16, 3, 1'b1);

        // One row per rectangle at maximum height drives the atlas height into saturation.
        retune(0, 15);
        for (int i = 0; i < RECT_CAP; i++)
            push_rect($urandom_range(0, 2047), 2047, i == RECT_CAP - 1);

        // More rectangles than the store holds; the final one is dropped but still ends the set.
        retune(4096, 8176);
        for (int i = 0; i < RECT_CAP + 4; i++)
            push_rect($urandom_range(1, 1024), $urandom_range(1, 1024), i == RECT_CAP + 3);

        while (queued_rects < RECT_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       width_val = 16;
                1:       width_val = 4096;
                2:       width_val = 0;
                3:       width_val = 8191;
                4:       width_val = $urandom_range(0, 8191);
                default: width_val = $urandom_range(16, 4096);
            endcase
            pad_val = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(0, 15);
            retune(width_val, pad_val);
            phase_rects = 0;
            while (phase_rects < 40 && queued_rects < RECT_TARGET)
            begin
                case ($urandom_range(0, 29))
                    0:       set_len = $urandom_range(RECT_CAP + 1, RECT_CAP + 3);
                    1, 2:    set_len = $urandom_range(20, RECT_CAP);
                    default: set_len = $urandom_range(1, 10);
                endcase
                push_random_set(set_len);
                phase_rects += set_len;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (rect_feed_q.size() > 0 || rect_valid || cfg_valid || placement_q.size() > 0)
            @(posedge clk);
        repeat (END_GAP) @(posedge clk);

        if (fail_cnt == 0 && placement_q.size() == 0)
            $display("atlas_shelf_packer test passed");
        else
            $display("atlas_shelf_packer test failed");
        $finish;
    end

endmodule
